// File: rtl/iprbt_pkg.sv
`default_nettype none
package iprbt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ROW_W       = 8;
    localparam int CNT_W       = 9;
    localparam int IP_W        = 32;
    localparam int ENTRY_W     = 2 * IP_W;

    typedef enum logic [2:0] {
        OP_LOOKUP  = 3'd0,
        OP_APPEND  = 3'd1,
        OP_REPLACE = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_WILDCARD = 2'd1,
        ST_FULL         = 2'd2,
        ST_BAD_ROW      = 2'd3
    } status_t;

    localparam logic [1:0] FAM_IPV4   = 2'd0;
    localparam logic [1:0] FAM_MAPPED = 2'd1;
    localparam logic [1:0] FAM_OTHER  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOP,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic set_status;
        logic wr_entry;
        logic count_inc;
        logic count_clr;
        logic rd_issue;
        logic count_sub;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic err;
        logic fam_ok;
        logic rp_at_end;
    } dp_stat_t;

    function automatic logic wildcard_ok(input logic [3:0] octets);
        logic ok;
        unique case (octets)
            4'h0, 4'h1, 4'h3, 4'h7, 4'hF: ok = 1'b1;
            default:                      ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [IP_W-1:0] wildcard_mask(input logic [3:0] octets);
        logic [IP_W-1:0] mask;
        unique case (octets)
            4'h1:    mask = 32'h0000_00FF;
            4'h3:    mask = 32'h0000_FFFF;
            4'h7:    mask = 32'h00FF_FFFF;
            4'hF:    mask = 32'hFFFF_FFFF;
            default: mask = 32'h0000_0000;
        endcase
        return mask;
    endfunction

endpackage
`default_nettype wire

// File: rtl/iprbt_ram.sv
`default_nettype none
module iprbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/iprbt_ctrl.sv
`default_nettype none
module iprbt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire iprbt_pkg::dp_stat_t  stat,
    output iprbt_pkg::ctrl_cmd_t      cmd,
    output logic                      busy
);
    import iprbt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_FINISH;
                if (!stat.err)
                begin
                    case (stat.op)
                        OP_LOOKUP:
                        begin
                            if (stat.fam_ok)
                            begin
                                state_next = S_LOOP;
                            end
                        end
                        OP_APPEND:
                        begin
                            cmd.wr_entry  = 1'b1;
                            cmd.count_inc = 1'b1;
                        end
                        OP_REPLACE: cmd.wr_entry  = 1'b1;
                        OP_REMOVE:  state_next    = S_LOOP;
                        OP_CLEAR:   cmd.count_clr = 1'b1;
                        default:    state_next    = S_FINISH;
                    endcase
                end
            end
            S_LOOP:
            begin
                if (stat.rp_at_end)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            S_DRAIN:
            begin
                cmd.count_sub = (stat.op == OP_REMOVE);
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/iprbt_datapath.sv
`default_nettype none
module iprbt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire iprbt_pkg::ctrl_cmd_t          cmd,
    output iprbt_pkg::dp_stat_t                stat,
    input  wire logic [2:0]                    op,
    input  wire logic [1:0]                    addr_family,
    input  wire logic [iprbt_pkg::IP_W-1:0]    address,
    input  wire logic [iprbt_pkg::IP_W-1:0]    range_start,
    input  wire logic [iprbt_pkg::IP_W-1:0]    range_end,
    input  wire logic                          use_wildcard,
    input  wire logic [3:0]                    wildcard_octets,
    input  wire logic [iprbt_pkg::ROW_W-1:0]   row,
    input  wire logic [iprbt_pkg::CNT_W-1:0]   remove_count,
    output logic                               done,
    output logic                               blocked,
    output logic [1:0]                         status,
    output logic [iprbt_pkg::CNT_W-1:0]        entry_total
);
    import iprbt_pkg::*;

    op_t               op_reg;
    logic [1:0]        fam_reg;
    logic [IP_W-1:0]   addr_reg;
    logic [IP_W-1:0]   start_reg;
    logic [IP_W-1:0]   end_reg;
    logic              wild_reg;
    logic [3:0]        octets_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  rp_reg;
    logic [CNT_W-1:0]  rp_next;
    logic [ROW_W-1:0]  wp_reg;
    logic [ROW_W-1:0]  wp_next;
    logic              rd_v_reg;
    logic              hit_reg;
    logic              hit_next;
    logic              done_reg;
    status_t           status_reg;

    logic [IP_W-1:0]   wmask;
    logic [IP_W-1:0]   entry_s;
    logic [IP_W-1:0]   entry_e;
    logic              bad_wild;
    logic              full;
    logic              bad_replace;
    logic              bad_remove;
    logic [CNT_W:0]    remove_end;
    status_t           err_code;

    logic              ram_we;
    logic [ROW_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [IP_W-1:0]   q_s;
    logic [IP_W-1:0]   q_e;
    logic              shift_wr;
    logic              match;

    assign wmask    = wildcard_mask(octets_reg);
    assign entry_s  = wild_reg ? (start_reg & ~wmask) : start_reg;
    assign entry_e  = wild_reg ? ((start_reg & ~wmask) | wmask) : end_reg;
    assign bad_wild = wild_reg && !wildcard_ok(octets_reg);
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));

    assign bad_replace = ({1'b0, row_reg} >= count_reg);
    assign remove_end  = {2'b00, row_reg} + {1'b0, cnt_reg};
    assign bad_remove  = (remove_end > {1'b0, count_reg});

    always_comb
    begin
        err_code = ST_OK;
        case (op_reg)
            OP_APPEND:
            begin
                if (bad_wild)
                begin
                    err_code = ST_BAD_WILDCARD;
                end
                else if (full)
                begin
                    err_code = ST_FULL;
                end
            end
            OP_REPLACE:
            begin
                if (bad_replace)
                begin
                    err_code = ST_BAD_ROW;
                end
                else if (bad_wild)
                begin
                    err_code = ST_BAD_WILDCARD;
                end
            end
            OP_REMOVE:
            begin
                if (bad_remove)
                begin
                    err_code = ST_BAD_ROW;
                end
            end
            default: err_code = ST_OK;
        endcase
    end

    assign stat.op        = op_reg;
    assign stat.err       = (err_code != ST_OK);
    assign stat.fam_ok    = (fam_reg == FAM_IPV4) || (fam_reg == FAM_MAPPED);
    assign stat.rp_at_end = (rp_reg == count_reg);

    assign q_s      = ram_rdata[ENTRY_W-1:IP_W];
    assign q_e      = ram_rdata[IP_W-1:0];
    assign shift_wr = rd_v_reg && (op_reg == OP_REMOVE);
    assign match    = rd_v_reg && (op_reg == OP_LOOKUP) && (q_s <= addr_reg)
                      && (addr_reg <= q_e);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = ram_rdata;
        if (cmd.wr_entry)
        begin
            ram_we    = 1'b1;
            ram_waddr = (op_reg == OP_APPEND) ? count_reg[ROW_W-1:0] : row_reg;
            ram_wdata = {entry_s, entry_e};
        end
        else if (shift_wr)
        begin
            ram_we = 1'b1;
        end
    end

    iprbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rp_reg[ROW_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        hit_next   = hit_reg | match;
        if (cmd.load)
        begin
            rp_next  = (op == OP_REMOVE) ? (CNT_W'(row) + remove_count) : '0;
            wp_next  = row;
            hit_next = 1'b0;
        end
        else
        begin
            if (cmd.rd_issue)
            begin
                rp_next = rp_reg + 1'b1;
            end
            if (shift_wr)
            begin
                wp_next = wp_reg + 1'b1;
            end
        end
        if (cmd.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.count_sub)
        begin
            count_next = count_reg - cnt_reg;
        end
        else if (cmd.count_clr)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rp_reg     <= '0;
            wp_reg     <= '0;
            rd_v_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg <= count_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            rd_v_reg  <= cmd.rd_issue;
            hit_reg   <= hit_next;
            done_reg  <= cmd.finish;
            if (cmd.set_status)
            begin
                status_reg <= err_code;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(op);
            fam_reg    <= addr_family;
            addr_reg   <= address;
            start_reg  <= range_start;
            end_reg    <= range_end;
            wild_reg   <= use_wildcard;
            octets_reg <= wildcard_octets;
            row_reg    <= row;
            cnt_reg    <= remove_count;
        end
    end

    assign done        = done_reg;
    assign blocked     = hit_reg;
    assign status      = status_reg;
    assign entry_total = count_reg;

endmodule
`default_nettype wire

// File: rtl/ipv4_range_block_table_unit.sv
// IPv4 range block table.
// Command channel: present op and its fields with start high; the item is
// taken at a rising edge where start is high and busy is low. busy stays high
// until the result has been produced.
// Result channel: done pulses for one cycle with blocked, status and
// entry_total; the receiver must take it in that cycle.
// Lookup reads the stored ranges in order, one stored range read per cycle;
// remove moves each row past the removed ones down to close the gap, one
// row moved per cycle. Append, replace, clear, a rejected item and a lookup
// of a family other than IPv4 or IPv4-mapped do no scan.
// A new item can be accepted in the cycle done is high. The single-port read
// of the range store sets the scan and shift rate.
// Reset empties the table at once; no clearing pass is needed.
`default_nettype none
module ipv4_range_block_table_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    op,
    input  wire logic [1:0]                    addr_family,
    input  wire logic [iprbt_pkg::IP_W-1:0]    address,
    input  wire logic [iprbt_pkg::IP_W-1:0]    range_start,
    input  wire logic [iprbt_pkg::IP_W-1:0]    range_end,
    input  wire logic                          use_wildcard,
    input  wire logic [3:0]                    wildcard_octets,
    input  wire logic [iprbt_pkg::ROW_W-1:0]   row,
    input  wire logic [iprbt_pkg::CNT_W-1:0]   remove_count,
    output logic                               done,
    output logic                               blocked,
    output logic [1:0]                         status,
    output logic [iprbt_pkg::CNT_W-1:0]        entry_total
);
    import iprbt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    iprbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    iprbt_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .op              (op),
        .addr_family     (addr_family),
        .address         (address),
        .range_start     (range_start),
        .range_end       (range_end),
        .use_wildcard    (use_wildcard),
        .wildcard_octets (wildcard_octets),
        .row             (row),
        .remove_count    (remove_count),
        .done            (done),
        .blocked         (blocked),
        .status          (status),
        .entry_total     (entry_total)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_blocked_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && blocked |-> status == ST_OK)
        else $error("blocked with error status");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_total <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_CLEAR |=> ##2 (done && entry_total == '0))
        else $error("clear did not complete");

endmodule
`default_nettype wire
